// File: rtl/stge_pkg.sv
// ----------------------------------------------------------------------------
// stge_pkg: shared types and constants for the symbol table greedy encoder
// Holds table geometry, opcodes and the front-to-back command record.
// ----------------------------------------------------------------------------
package stge_pkg;

	localparam int TableEntries   = 255;
	localparam int MaxSymbolBytes = 8;
	localparam int CountWidth     = 16;
	localparam int IdxW           = 8;
	localparam int LenW           = 4;
	localparam int CmdDepth       = 4;
	localparam int CmdPtrW        = 2;
	localparam logic [7:0] EscapeCode = 8'd255;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEXT = 1'b1
	} opcode_t;

	typedef enum logic [0:0] {
		REG_SYMBOL_COUNT = 1'b0,
		REG_OUTPUT_CAP   = 1'b1
	} reg_index_t;

	typedef struct packed {
		opcode_t     op;
		logic [7:0]  entry_index;
		logic [63:0] entry_bytes;
		logic [3:0]  entry_length;
		logic [7:0]  text_byte;
		logic        text_last;
	} cmd_t;

	typedef struct packed {
		logic        code_valid;
		logic [7:0]  code;
		logic [7:0]  literal;
		logic        has_literal;
		logic        last;
		logic        complete;
		logic [15:0] written_count;
	} res_t;

endpackage

// File: rtl/stge_if.sv
// ----------------------------------------------------------------------------
// stge_in_if / stge_out_if: valid/ready channels of the encoder
// Input items and result items with source and sink modports.
// ----------------------------------------------------------------------------
interface stge_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  entry_index;
	logic [63:0] entry_bytes;
	logic [3:0]  entry_length;
	logic [7:0]  text_byte;
	logic        text_last;
	modport source (output valid, opcode, entry_index, entry_bytes, entry_length,
		text_byte, text_last, input ready);
	modport sink (input valid, opcode, entry_index, entry_bytes, entry_length,
		text_byte, text_last, output ready);
endinterface

interface stge_out_if;
	logic        valid;
	logic        ready;
	logic        code_valid;
	logic [7:0]  code;
	logic [7:0]  literal;
	logic        has_literal;
	logic        last;
	logic        complete;
	logic [15:0] written_count;
	modport source (output valid, code_valid, code, literal, has_literal, last,
		complete, written_count, input ready);
	modport sink (input valid, code_valid, code, literal, has_literal, last,
		complete, written_count, output ready);
endinterface

// File: rtl/stge_front.sv
// ----------------------------------------------------------------------------
// stge_front: input acceptance and command queue
// Queues input items for the back end.
// ----------------------------------------------------------------------------
module stge_front import stge_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	stge_in_if.sink in_ch,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_pop
);
	cmd_t               fifo_q [CmdDepth];
	logic [CmdPtrW-1:0] wr_q, rd_q;
	logic [CmdPtrW:0]   cnt_q;
	logic               push;

	assign in_ch.ready = (cnt_q != (CmdPtrW+1)'(CmdDepth)) ? 1'b1 : 1'b0;
	assign push        = in_ch.valid & in_ch.ready;
	assign cmd_valid   = (cnt_q != '0);
	assign cmd         = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{op: opcode_t'(in_ch.opcode), entry_index: in_ch.entry_index,
				entry_bytes: in_ch.entry_bytes, entry_length: in_ch.entry_length,
				text_byte: in_ch.text_byte, text_last: in_ch.text_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (cmd_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (CmdPtrW+1)'(push) - (CmdPtrW+1)'(cmd_pop);
		end
	end
endmodule

// File: rtl/stge_back.sv
// ----------------------------------------------------------------------------
// stge_back: table store, window and longest-match scan
// Scans one table entry per cycle from memory and emits codes.
// ----------------------------------------------------------------------------
module stge_back import stge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  symbol_count,
	input  logic [15:0] output_capacity,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	stge_out_if.source  out_ch
);
	typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_READ, S_SCAN, S_EMIT, S_STATUS} state_t;

	logic [63:0] sym_mem [TableEntries];
	logic [3:0]  len_mem [TableEntries];
	logic [63:0] rd_sym_q;
	logic [3:0]  rd_len_q;

	state_t      state_q;
	logic [63:0] win_q;
	logic [3:0]  fill_q;
	logic [CountWidth-1:0] written_q;
	logic        halted_q;
	logic        drain_q;
	logic [7:0]  scan_q;
	logic [7:0]  scan_n_q;
	logic [3:0]  best_len_q;
	logic [7:0]  best_idx_q;
	logic        rd_ok_q;
	logic [2:0]  emit_cnt_q;
	res_t        res_q;
	logic        res_valid_q;

	logic [63:0] mask;
	logic        hit;
	logic [63:0] win_added;
	logic [CountWidth:0] wsum;
	logic [CountWidth-1:0] wnext;
	logic [3:0]  drop_len;
	logic        cap_hit;
	logic        next_halt;
	logic [3:0]  fill_next;
	logic [63:0] win_next;
	logic        emit_final;
	logic        out_free;
	logic        emit_fire;
	logic        status_fire;
	res_t        res_d;

	always_comb begin
		mask = '0;
		for (int b = 0; b < MaxSymbolBytes; b++)
			if (4'(b) < rd_len_q) mask[b*8 +: 8] = 8'hFF;
	end
	assign hit = rd_ok_q && (rd_len_q != 4'd0) && (rd_len_q <= fill_q)
		&& (((rd_sym_q ^ win_q) & mask) == '0) && (rd_len_q > best_len_q);
	assign win_added = win_q | ({56'd0, cmd.text_byte} << {fill_q[2:0], 3'b000});
	assign cap_hit = ({1'b0, written_q} + 1'b1) >= (CountWidth+1)'(output_capacity);
	assign drop_len = (best_idx_q == EscapeCode) ? 4'd1 : best_len_q;
	assign wsum = {1'b0, written_q}
		+ (CountWidth+1)'((best_idx_q == EscapeCode) ? 2'd2 : 2'd1);
	assign wnext = wsum[CountWidth] ? '1 : wsum[CountWidth-1:0];
	assign next_halt = ({1'b0, wnext} + 1'b1) >= (CountWidth+1)'(output_capacity);
	assign fill_next = (drop_len >= fill_q) ? 4'd0 : fill_q - drop_len;
	assign win_next = (drop_len >= 4'd8) ? '0 : win_q >> {drop_len[2:0], 3'b000};
	assign emit_final = drain_q && (fill_next == 4'd0 || emit_cnt_q == 3'd7 || next_halt);
	assign out_free = !res_valid_q || out_ch.ready;
	assign emit_fire = (state_q == S_EMIT) && out_free;
	assign status_fire = (state_q == S_STATUS) && out_free;

	always_comb begin
		res_d = '0;
		if (state_q == S_STATUS) begin
			res_d.last          = 1'b1;
			res_d.complete      = !halted_q && fill_q == 4'd0;
			res_d.written_count = 16'(written_q);
		end else begin
			res_d.code_valid = 1'b1;
			res_d.code       = best_idx_q;
			if (best_idx_q == EscapeCode) begin
				res_d.has_literal = 1'b1;
				res_d.literal     = win_q[7:0];
			end
			if (emit_final) begin
				res_d.last          = 1'b1;
				res_d.complete      = (fill_next == 4'd0);
				res_d.written_count = 16'(wnext);
			end
		end
	end

	assign out_ch.valid         = res_valid_q;
	assign out_ch.code_valid    = res_q.code_valid;
	assign out_ch.code          = res_q.code;
	assign out_ch.literal       = res_q.literal;
	assign out_ch.has_literal   = res_q.has_literal;
	assign out_ch.last          = res_q.last;
	assign out_ch.complete      = res_q.complete;
	assign out_ch.written_count = res_q.written_count;

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_LOAD && cmd.entry_index < IdxW'(TableEntries)) begin
			sym_mem[cmd.entry_index] <= cmd.entry_bytes;
			len_mem[cmd.entry_index] <= (cmd.entry_length > LenW'(MaxSymbolBytes))
				? LenW'(MaxSymbolBytes) : cmd.entry_length;
		end
		if (scan_q < IdxW'(TableEntries)) begin
			rd_sym_q <= sym_mem[scan_q];
			rd_len_q <= len_mem[scan_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= '0;
			fill_q      <= '0;
			written_q   <= '0;
			halted_q    <= 1'b0;
			drain_q     <= 1'b0;
			scan_q      <= '0;
			scan_n_q    <= '0;
			best_len_q  <= '0;
			best_idx_q  <= EscapeCode;
			rd_ok_q     <= 1'b0;
			emit_cnt_q  <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_fire || status_fire) begin
				res_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.op == OP_TEXT) begin
						if (!halted_q && fill_q < 4'd8) begin
							win_q  <= win_added;
							fill_q <= fill_q + 1'b1;
						end
						drain_q    <= cmd.text_last;
						emit_cnt_q <= '0;
						state_q    <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!halted_q && fill_q != 4'd0 && (drain_q || fill_q == 4'd8)) begin
						if (cap_hit) begin
							halted_q <= 1'b1;
						end else begin
							scan_q     <= '0;
							scan_n_q   <= (symbol_count > IdxW'(TableEntries))
								? IdxW'(TableEntries) : symbol_count;
							best_len_q <= '0;
							best_idx_q <= EscapeCode;
							rd_ok_q    <= 1'b0;
							state_q    <= S_READ;
						end
					end else if (drain_q) begin
						state_q <= S_STATUS;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (hit) begin
						best_len_q <= rd_len_q;
						best_idx_q <= scan_q - 1'b1;
					end
					rd_ok_q <= (scan_q < scan_n_q);
					if (scan_q == scan_n_q) state_q <= S_EMIT;
					else scan_q <= scan_q + 1'b1;
				end
				S_EMIT: begin
					if (emit_fire) begin
						emit_cnt_q <= emit_cnt_q + 1'b1;
						if (emit_final) begin
							win_q     <= '0;
							fill_q    <= '0;
							written_q <= '0;
							halted_q  <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							win_q     <= win_next;
							fill_q    <= fill_next;
							written_q <= wnext;
							state_q   <= drain_q ? S_DECIDE : S_IDLE;
						end
					end
				end
				S_STATUS: begin
					if (status_fire) begin
						win_q     <= '0;
						fill_q    <= '0;
						written_q <= '0;
						halted_q  <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/symbol_table_greedy_encoder_unit.sv
// ----------------------------------------------------------------------------
// symbol_table_greedy_encoder_unit: greedy longest-match table encoder
// Front queue accepts items; back end scans the symbol table per code.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   opcode, entry_index, entry_bytes, entry_length, text_byte, text_last
//  out_ch   out  code_valid, code, literal, has_literal, last, complete, written_count
//  cfg      in   cfg_we, cfg_index, cfg_data
// Each code passes through decide, a scan of the first symbol_count table entries
// reading one table entry per cycle from the symbol memory, and emit. A byte that
// fills the window starts a scan; a last byte drains up to eight codes, or gives
// a status result alone.
// Reset is asynchronous and clears control state; the table is undefined until
// loaded. A stalled result holds the back end at its next emit; the four-entry queue keeps accepting until full.
module symbol_table_greedy_encoder_unit import stge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	stge_in_if.sink     in_ch,
	stge_out_if.source  out_ch
);
	logic [7:0]  symbol_count_q;
	logic [15:0] output_capacity_q;
	logic        cmd_valid;
	cmd_t        cmd;
	logic        cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q    <= '0;
			output_capacity_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SYMBOL_COUNT: symbol_count_q    <= cfg_data[7:0];
				REG_OUTPUT_CAP:   output_capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	stge_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	stge_back u_back (
		.clk(clk), .arst_n(arst_n), .symbol_count(symbol_count_q),
		.output_capacity(output_capacity_q), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .out_ch(out_ch)
	);

	a_written_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.last |-> out_ch.written_count == 16'd0)
		else $error("written_count set on non-final result");
	a_lit_escape: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.has_literal |-> out_ch.code == EscapeCode)
		else $error("literal without escape");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped while stalled");
endmodule
